// File: design/ess_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ess_pkg
// Types, codes and commutation tables shared by the six-step commutator
// ----------------------------------------------------------------------------
package ess_pkg;

    localparam int ANGLE_W      = 14;
    localparam int STATE_W      = 3;
    localparam int PHASE_W      = 2;
    localparam int DUTY_W       = 8;
    localparam int COUNT_W      = 4;
    localparam int OPQ_DEPTH    = 2;
    localparam int OPQ_PTR_W    = $clog2(OPQ_DEPTH);
    localparam int OPQ_CNT_W    = $clog2(OPQ_DEPTH + 1);
    localparam int APB_ADDR_W   = 4;
    localparam int APB_DATA_W   = 32;

    localparam logic [STATE_W-1:0] NO_STATE  = 3'd6;
    localparam logic [STATE_W-1:0] MAX_STATE = 3'd5;
    localparam logic [PHASE_W-1:0] NO_PHASE  = 2'd3;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 4'd15;

    typedef enum logic
    {
        CMD_SAMPLE    = 1'b0,
        CMD_MAP_WRITE = 1'b1
    } ess_cmd_t;

    typedef enum logic [1:0]
    {
        REG_THRUST_DUTY   = 2'd0,
        REG_ROTATION_DIR  = 2'd1,
        REG_REVERSE_LIMIT = 2'd2
    } ess_reg_t;

    typedef enum logic [PHASE_W-1:0]
    {
        PHASE_A = 2'd0,
        PHASE_B = 2'd1,
        PHASE_C = 2'd2
    } ess_phase_t;

    typedef struct packed
    {
        logic               cmd;
        logic [ANGLE_W-1:0] angle;
        logic               map_dir;
        logic [STATE_W-1:0] map_state;
    } ess_in_t;

    typedef struct packed
    {
        logic [STATE_W-1:0] comm_state;
        logic [PHASE_W-1:0] high_phase;
        logic [PHASE_W-1:0] low_phase;
        logic [DUTY_W-1:0]  duty;
        logic               fault_latched;
        logic               reverse_alarm;
    } ess_out_t;

    // classified request handed from the front to the back
    typedef struct packed
    {
        logic               is_sample;
        logic [STATE_W-1:0] map_val;
    } ess_op_t;

    typedef struct packed
    {
        logic [DUTY_W-1:0]  thrust_duty;
        logic               rotation_dir;
        logic [COUNT_W-1:0] reverse_limit;
    } ess_cfg_t;

    // successor of a state; dir 0 clockwise, 1 counter-clockwise
    function automatic logic [STATE_W-1:0] succ_state(input logic [STATE_W-1:0] st,
                                                      input logic dir);
        logic [STATE_W-1:0] res;
        begin
            unique case (st)
                3'd0:    res = dir ? 3'd1 : 3'd5;
                3'd1:    res = dir ? 3'd2 : 3'd0;
                3'd2:    res = dir ? 3'd3 : 3'd1;
                3'd3:    res = dir ? 3'd4 : 3'd2;
                3'd4:    res = dir ? 3'd5 : 3'd3;
                3'd5:    res = dir ? 3'd0 : 3'd4;
                default: res = NO_STATE;
            endcase
            return res;
        end
    endfunction

    function automatic logic [PHASE_W-1:0] high_of(input logic [STATE_W-1:0] st);
        logic [PHASE_W-1:0] res;
        begin
            unique case (st)
                3'd0, 3'd1: res = PHASE_A;
                3'd2, 3'd3: res = PHASE_B;
                3'd4, 3'd5: res = PHASE_C;
                default:    res = NO_PHASE;
            endcase
            return res;
        end
    endfunction

    function automatic logic [PHASE_W-1:0] low_of(input logic [STATE_W-1:0] st);
        logic [PHASE_W-1:0] res;
        begin
            unique case (st)
                3'd0, 3'd5: res = PHASE_B;
                3'd1, 3'd2: res = PHASE_C;
                3'd3, 3'd4: res = PHASE_A;
                default:    res = NO_PHASE;
            endcase
            return res;
        end
    endfunction

endpackage
`default_nettype wire

// File: design/ess_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ess_front
// Accepts requests, writes or reads the angle-to-state table, classifies
// ----------------------------------------------------------------------------
module ess_front
    import ess_pkg::*;
#(
    parameter int ANGLE_BITS = 14
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire ess_in_t  item,
    output logic          full,
    input  wire logic     rotation_dir,
    output logic          op_valid,
    output ess_op_t       op,
    input  wire logic     op_ready
);

    localparam int MAP_DEPTH = 2 << ANGLE_BITS;

    logic [STATE_W-1:0]    map_mem [MAP_DEPTH];
    logic [ANGLE_BITS-1:0] angle_idx;
    logic                  accept;
    logic                  op_valid_reg;
    logic                  op_valid_next;
    logic                  is_sample_reg;
    logic [STATE_W-1:0]    rd_data_reg;

    generate
        if (ANGLE_BITS <= ANGLE_W)
        begin : g_angle_trunc
            assign angle_idx = item.angle[ANGLE_BITS-1:0];
        end
        else
        begin : g_angle_ext
            assign angle_idx = {{(ANGLE_BITS - ANGLE_W){1'b0}}, item.angle};
        end
    endgenerate

    assign full   = op_valid_reg && !op_ready;
    assign accept = push && !full;

    always_comb
    begin
        if (accept)
            op_valid_next = 1'b1;
        else if (op_ready)
            op_valid_next = 1'b0;
        else
            op_valid_next = op_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            op_valid_reg <= 1'b0;
        else
            op_valid_reg <= op_valid_next;
    end

    // table write and table read share the request order, so a sample sees
    // every entry written before it
    always_ff @(posedge clk)
    begin
        if (accept && item.cmd == CMD_MAP_WRITE)
            map_mem[{item.map_dir, angle_idx}] <= item.map_state;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_data_reg   <= map_mem[{rotation_dir, angle_idx}];
            is_sample_reg <= (item.cmd == CMD_SAMPLE);
        end
    end

    assign op_valid     = op_valid_reg;
    assign op.is_sample = is_sample_reg;
    assign op.map_val   = rd_data_reg;

endmodule
`default_nettype wire

// File: design/ess_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ess_fifo
// Short queue of classified requests between front and back
// ----------------------------------------------------------------------------
module ess_fifo
    import ess_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     wr_en,
    input  wire ess_op_t  wr_data,
    output logic          ready,
    input  wire logic     rd_en,
    output logic          valid,
    output ess_op_t       rd_data
);

    ess_op_t                entry_reg [OPQ_DEPTH];
    logic [OPQ_PTR_W-1:0]   wr_ptr_reg;
    logic [OPQ_PTR_W-1:0]   rd_ptr_reg;
    logic [OPQ_CNT_W-1:0]   cnt_reg;
    logic [OPQ_CNT_W-1:0]   cnt_next;
    logic                   do_wr;
    logic                   do_rd;

    assign ready = (cnt_reg != OPQ_CNT_W'(OPQ_DEPTH));
    assign valid = (cnt_reg != '0);
    assign do_wr = wr_en && ready;
    assign do_rd = rd_en && valid;

    always_comb
    begin
        unique case ({do_wr, do_rd})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (do_wr)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_rd)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            entry_reg[wr_ptr_reg] <= wr_data;
    end

    assign rd_data = entry_reg[rd_ptr_reg];

endmodule
`default_nettype wire

// File: design/ess_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ess_back
// Commutation state machine, reverse counter, fault latch and result register
// ----------------------------------------------------------------------------
module ess_back
    import ess_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire ess_cfg_t  cfg,
    input  wire logic      op_valid,
    input  wire ess_op_t   op,
    output logic           op_take,
    output logic           empty,
    output ess_out_t       result,
    input  wire logic      pop
);

    logic [STATE_W-1:0] cur_state_reg, cur_state_next;
    logic [COUNT_W-1:0] rev_cnt_reg, rev_cnt_next;
    logic               fault_reg, fault_next;
    logic [PHASE_W-1:0] drv_high_reg, drv_high_next;
    logic [PHASE_W-1:0] drv_low_reg, drv_low_next;
    logic [DUTY_W-1:0]  drv_duty_reg, drv_duty_next;
    logic               alarm;
    logic               out_valid_reg;
    ess_out_t           out_reg;
    logic [STATE_W-1:0] ns;
    logic [STATE_W-1:0] fwd_state;
    logic [STATE_W-1:0] rev_state;
    logic               commute;

    assign op_take = op_valid && (!out_valid_reg || pop);
    assign ns        = op.map_val;
    assign fwd_state = succ_state(cur_state_reg, cfg.rotation_dir);
    assign rev_state = succ_state(cur_state_reg, !cfg.rotation_dir);

    always_comb
    begin
        cur_state_next = cur_state_reg;
        rev_cnt_next   = rev_cnt_reg;
        fault_next     = fault_reg;
        drv_high_next  = drv_high_reg;
        drv_low_next   = drv_low_reg;
        drv_duty_next  = drv_duty_reg;
        alarm          = 1'b0;
        commute        = 1'b0;
        if (op.is_sample && !fault_reg && cfg.thrust_duty != '0 && ns != cur_state_reg)
        begin
            if (cur_state_reg != NO_STATE)
            begin
                priority if (ns == fwd_state)
                begin
                    rev_cnt_next = '0;
                    commute      = 1'b1;
                end
                else if (ns == rev_state)
                begin
                    if (rev_cnt_reg != COUNT_MAX)
                        rev_cnt_next = rev_cnt_reg + 1'b1;
                    alarm   = (rev_cnt_next > cfg.reverse_limit);
                    commute = 1'b1;
                end
                else
                begin
                    // skipped step or invalid entry: latch fault and kill the drives
                    fault_next    = 1'b1;
                    drv_high_next = NO_PHASE;
                    drv_low_next  = NO_PHASE;
                    drv_duty_next = '0;
                end
            end
            else if (ns <= MAX_STATE)
            begin
                commute = 1'b1;
            end
            if (commute)
            begin
                drv_high_next  = high_of(ns);
                drv_low_next   = low_of(ns);
                drv_duty_next  = cfg.thrust_duty;
                cur_state_next = ns;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_state_reg <= NO_STATE;
            rev_cnt_reg   <= '0;
            fault_reg     <= 1'b0;
            drv_high_reg  <= NO_PHASE;
            drv_low_reg   <= NO_PHASE;
            drv_duty_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (op_take)
            begin
                cur_state_reg <= cur_state_next;
                rev_cnt_reg   <= rev_cnt_next;
                fault_reg     <= fault_next;
                drv_high_reg  <= drv_high_next;
                drv_low_reg   <= drv_low_next;
                drv_duty_reg  <= drv_duty_next;
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (op_take)
        begin
            out_reg.comm_state    <= cur_state_next;
            out_reg.high_phase    <= drv_high_next;
            out_reg.low_phase     <= drv_low_next;
            out_reg.duty          <= drv_duty_next;
            out_reg.fault_latched <= fault_next;
            out_reg.reverse_alarm <= alarm;
        end
    end

    assign empty  = !out_valid_reg;
    assign result = out_reg;

    a_fault_drives_off: assert property (@(posedge clk) disable iff (!rst_n)
        fault_reg |-> (drv_high_reg == NO_PHASE && drv_low_reg == NO_PHASE
                       && drv_duty_reg == '0))
        else $error("drives active while faulted");

    a_fault_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        fault_reg |=> fault_reg)
        else $error("fault latch cleared without reset");

    a_state_legal: assert property (@(posedge clk) disable iff (!rst_n)
        cur_state_reg <= NO_STATE)
        else $error("commutation state out of range");

    a_alarm_needs_commute: assert property (@(posedge clk) disable iff (!rst_n)
        (op_take && alarm) |=> (rev_cnt_reg != '0 && !fault_reg))
        else $error("reverse alarm without a reverse step");

endmodule
`default_nettype wire

// File: design/encoder_six_step_commutator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// encoder_six_step_commutator
// Six-step commutation from encoder angle samples through a loaded angle table
// ----------------------------------------------------------------------------
// path: front request registers, queue entry, then the result register
// throughput: one request per cycle while results are popped; else full stalls
// reset: state none, counter and fault cleared, drives off, registers to reset
// values; the angle table holds garbage until each entry is written
// ----------------------------------------------------------------------------
module encoder_six_step_commutator
    import ess_pkg::*;
#(
    parameter int ANGLE_BITS = 14
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    input  wire ess_in_t                item,
    output logic                        full,
    output logic                        empty,
    output ess_out_t                    result,
    input  wire logic                   pop,
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [APB_ADDR_W-1:0]  paddr,
    input  wire logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]       prdata,
    output logic                        pready
);

    ess_cfg_t cfg_reg;
    ess_reg_t reg_sel;
    logic     cfg_wr;
    logic     front_valid;
    ess_op_t  front_op;
    logic     opq_ready;
    logic     opq_valid;
    ess_op_t  opq_data;
    logic     op_take;

    assign pready  = 1'b1;
    assign reg_sel = ess_reg_t'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.thrust_duty   <= '0;
            cfg_reg.rotation_dir  <= 1'b0;
            cfg_reg.reverse_limit <= 4'd1;
        end
        else if (cfg_wr)
        begin
            unique case (reg_sel)
                REG_THRUST_DUTY:   cfg_reg.thrust_duty   <= pwdata[DUTY_W-1:0];
                REG_ROTATION_DIR:  cfg_reg.rotation_dir  <= pwdata[0];
                REG_REVERSE_LIMIT: cfg_reg.reverse_limit <= pwdata[COUNT_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_THRUST_DUTY:   prdata = APB_DATA_W'(cfg_reg.thrust_duty);
            REG_ROTATION_DIR:  prdata = APB_DATA_W'(cfg_reg.rotation_dir);
            REG_REVERSE_LIMIT: prdata = APB_DATA_W'(cfg_reg.reverse_limit);
            default:           prdata = '0;
        endcase
    end

    ess_front #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .item         (item),
        .full         (full),
        .rotation_dir (cfg_reg.rotation_dir),
        .op_valid     (front_valid),
        .op           (front_op),
        .op_ready     (opq_ready)
    );

    ess_fifo u_opq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (front_valid),
        .wr_data (front_op),
        .ready   (opq_ready),
        .rd_en   (op_take),
        .valid   (opq_valid),
        .rd_data (opq_data)
    );

    ess_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .op_valid (opq_valid),
        .op       (opq_data),
        .op_take  (op_take),
        .empty    (empty),
        .result   (result),
        .pop      (pop)
    );

endmodule
`default_nettype wire

// File: tb/ess_commutation_checker.sv
// ----------------------------------------------------------------------------
// ess_commutation_checker
// Predicts the commutator's drive outputs for every accepted request and
// compares them, field by field and in order, with the results popped from
// the block. Register writes on the configuration port are followed so that
// the prediction uses the same settings as the block.
// ----------------------------------------------------------------------------
module ess_commutation_checker
    import ess_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire logic                  full,
    input  wire ess_in_t               item,
    input  wire logic                  pop,
    input  wire logic                  empty,
    input  wire ess_out_t              result,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic                  pready,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output int                         errors,
    output int                         n_requests,
    output int                         n_results
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [STATE_W-1:0] angle_table [0:(2 << ANGLE_W) - 1];
    logic [STATE_W-1:0] state_now;
    logic [COUNT_W-1:0] reverse_run;
    logic               tripped;
    logic [PHASE_W-1:0] drive_hi;
    logic [PHASE_W-1:0] drive_lo;
    logic [DUTY_W-1:0]  drive_duty;
    ess_cfg_t           cfg;
    ess_out_t           due_outputs [$];

    // one step round the six states; ccw counts up, cw counts down
    function automatic logic [STATE_W-1:0] next_state(input logic [STATE_W-1:0] st,
                                                      input logic ccw);
        if (ccw)
            return (st == MAX_STATE) ? 3'd0 : st + 3'd1;
        return (st == 3'd0) ? MAX_STATE : st - 3'd1;
    endfunction

    function automatic logic [PHASE_W-1:0] high_side(input logic [STATE_W-1:0] st);
        case (st)
            3'd0, 3'd1: return PHASE_A;
            3'd2, 3'd3: return PHASE_B;
            default:    return PHASE_C;
        endcase
    endfunction

    function automatic logic [PHASE_W-1:0] low_side(input logic [STATE_W-1:0] st);
        case (st)
            3'd0, 3'd5: return PHASE_B;
            3'd1, 3'd2: return PHASE_C;
            default:    return PHASE_A;
        endcase
    endfunction

    function automatic ess_out_t commutate(input ess_in_t req);
        logic [STATE_W-1:0] seen;
        logic               alarm;
        ess_out_t           out;
        alarm = 1'b0;
        if (req.cmd == CMD_MAP_WRITE)
            angle_table[{req.map_dir, req.angle}] = req.map_state;
        else if (!tripped && cfg.thrust_duty != '0)
        begin
            seen = angle_table[{cfg.rotation_dir, req.angle}];
            if (seen != state_now)
            begin
                if (state_now <= MAX_STATE)
                begin
                    if (seen == next_state(state_now, cfg.rotation_dir))
                        reverse_run = '0;
                    else if (seen == next_state(state_now, !cfg.rotation_dir))
                    begin
                        if (reverse_run != COUNT_MAX)
                            reverse_run = reverse_run + 1'b1;
                        alarm = (reverse_run > cfg.reverse_limit);
                    end
                    else
                    begin
                        // skipped step or invalid entry: drives off for good
                        tripped    = 1'b1;
                        drive_hi   = NO_PHASE;
                        drive_lo   = NO_PHASE;
                        drive_duty = '0;
                    end
                end
                if (!tripped && seen <= MAX_STATE)
                begin
                    drive_hi   = high_side(seen);
                    drive_lo   = low_side(seen);
                    drive_duty = cfg.thrust_duty;
                    state_now  = seen;
                end
            end
        end
        out.comm_state    = state_now;
        out.high_phase    = drive_hi;
        out.low_phase     = drive_lo;
        out.duty          = drive_duty;
        out.fault_latched = tripped;
        out.reverse_alarm = alarm;
        return out;
    endfunction

    function automatic int field_diff(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
        if (got === want)
            return 0;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        return 1;
    endfunction

    function automatic int count_mismatches(input ess_out_t want, input ess_out_t got);
        int bad;
        bad  = field_diff("comm_state", 8'(want.comm_state), 8'(got.comm_state));
        bad += field_diff("high_phase", 8'(want.high_phase), 8'(got.high_phase));
        bad += field_diff("low_phase", 8'(want.low_phase), 8'(got.low_phase));
        bad += field_diff("duty", want.duty, got.duty);
        bad += field_diff("fault_latched", 8'(want.fault_latched), 8'(got.fault_latched));
        bad += field_diff("reverse_alarm", 8'(want.reverse_alarm), 8'(got.reverse_alarm));
        return bad;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        int       bad;
        ess_out_t want;
        if (!rst_n)
        begin
            state_now         = NO_STATE;
            reverse_run       = '0;
            tripped           = 1'b0;
            drive_hi          = NO_PHASE;
            drive_lo          = NO_PHASE;
            drive_duty        = '0;
            cfg.thrust_duty   = '0;
            cfg.rotation_dir  = 1'b0;
            cfg.reverse_limit = 4'd1;
            due_outputs.delete();
            errors     <= 0;
            n_requests <= 0;
            n_results  <= 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (due_outputs.size() == 0)
                begin
                    $display("%0t: result with no request outstanding, expected none, got %h",
                             $time, result);
                    bad = 1;
                end
                else
                begin
                    want = due_outputs.pop_front();
                    bad  = count_mismatches(want, result);
                end
                errors    <= errors + bad;
                n_results <= n_results + 1;
            end
            if (push && !full)
            begin
                due_outputs.push_back(commutate(item));
                n_requests <= n_requests + 1;
            end
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    REG_THRUST_DUTY:   cfg.thrust_duty   = pwdata[DUTY_W-1:0];
                    REG_ROTATION_DIR:  cfg.rotation_dir  = pwdata[0];
                    REG_REVERSE_LIMIT: cfg.reverse_limit = pwdata[COUNT_W-1:0];
                    default:           ;
                endcase
            end
        end
    end

endmodule

// File: tb/tb_encoder_six_step_commutator.sv
// ----------------------------------------------------------------------------
// tb_encoder_six_step_commutator
// Loads angle table entries and drives encoder samples that walk the rotor
// forwards, backwards and in place under a series of register settings, with
// random gaps and back-pressure; a skipped step or invalid entry closes the run.
// ----------------------------------------------------------------------------
module tb_encoder_six_step_commutator;
    timeunit 1ns;
    timeprecision 1ps;
    import ess_pkg::*;

    localparam int CLK_PERIOD   = 4;
    localparam int RESET_CYCLES = 6;
    localparam int LIMIT        = 200000;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 78;
    localparam int SETTLE       = 8;

    logic                  clk     = 1'b0;
    logic                  rst_n   = 1'b0;
    logic                  push    = 1'b0;
    ess_in_t               item    = '0;
    logic                  pop     = 1'b0;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic                  full;
    logic                  empty;
    ess_out_t              result;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int          errors;
    int          n_requests;
    int          n_results;
    int unsigned cycle_count = 0;
    bit          steady      = 1'b0;
    int          idle_pct    = 0;

    // what the stimulus believes is in the table and where the rotor is
    logic [STATE_W-1:0] entry_of [int];
    int                 keys_of [16][$];
    logic [DUTY_W-1:0]  thrust = '0;
    logic               ccw    = 1'b0;
    logic [STATE_W-1:0] rotor  = NO_STATE;
    int                 n_writes   = 0;
    int                 n_samples  = 0;
    int                 n_settings = 0;
    int                 counted    = 0;

    encoder_six_step_commutator #(.ANGLE_BITS(ANGLE_W)) i_dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .item    (item),
        .full    (full),
        .empty   (empty),
        .result  (result),
        .pop     (pop),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    ess_commutation_checker i_checker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .item       (item),
        .pop        (pop),
        .empty      (empty),
        .result     (result),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .errors     (errors),
        .n_requests (n_requests),
        .n_results  (n_results)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count == LIMIT);
        $display("timed out after %0d cycles", LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    // result side: random stall bursts until the closing stretch
    initial
    begin
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (!steady && $urandom_range(0, 5) == 0)
            begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
            else
            begin
                pop <= 1'b1;
                @(posedge clk);
            end
        end
    end

    task automatic send(input ess_in_t req);
        if (!steady && $urandom_range(0, 99) < idle_pct)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        push <= 1'b1;
        item <= req;
        @(posedge clk);
        while (full)
            @(posedge clk);
        counted++;
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        @(posedge clk);
        while (n_requests != n_results)
            @(posedge clk);
    endtask

    task automatic write_reg(input ess_reg_t idx, input logic [APB_DATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'({idx, 2'b00});
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input logic [DUTY_W-1:0] duty, input logic dir,
                             input logic [COUNT_W-1:0] lim);
        write_reg(REG_THRUST_DUTY, APB_DATA_W'(duty));
        write_reg(REG_ROTATION_DIR, APB_DATA_W'(dir));
        write_reg(REG_REVERSE_LIMIT, APB_DATA_W'(lim));
        thrust = duty;
        ccw    = dir;
        n_settings++;
    endtask

    task automatic write_entry(input logic dir, input logic [ANGLE_W-1:0] ang,
                               input logic [STATE_W-1:0] st);
        ess_in_t req;
        req.cmd       = CMD_MAP_WRITE;
        req.angle     = ang;
        req.map_dir   = dir;
        req.map_state = st;
        send(req);
        entry_of[int'({dir, ang})] = st;
        keys_of[{dir, st}].push_back(int'({dir, ang}));
        n_writes++;
    endtask

    task automatic sample_angle(input logic [ANGLE_W-1:0] ang);
        ess_in_t req;
        req.cmd       = CMD_SAMPLE;
        req.angle     = ang;
        req.map_dir   = 1'($urandom_range(0, 1));
        req.map_state = 3'($urandom_range(0, 7));
        send(req);
        n_samples++;
    endtask

    // sample an angle whose entry in the active half holds st, loading one if needed
    task automatic sample_state(input logic [STATE_W-1:0] st);
        int key;
        bit found;
        found = 1'b0;
        key   = 0;
        if (keys_of[{ccw, st}].size() != 0)
            for (int tries = 0; tries < 4 && !found; tries++)
            begin
                key   = keys_of[{ccw, st}][$urandom_range(0, keys_of[{ccw, st}].size() - 1)];
                found = (entry_of[key] == st);
            end
        if (!found)
        begin
            key = int'({ccw, ANGLE_W'($urandom_range(0, (1 << ANGLE_W) - 1))});
            write_entry(ccw, key[ANGLE_W-1:0], st);
        end
        sample_angle(key[ANGLE_W-1:0]);
    endtask

    task automatic turn(input bit backward);
        logic [STATE_W-1:0] target;
        if (rotor == NO_STATE)
            target = 3'($urandom_range(0, 5));
        else
            target = 3'((int'(rotor) + ((ccw ^ backward) ? 1 : 5)) % 6);
        sample_state(target);
        if (thrust != '0)
            rotor = target;
    endtask

    // no change of state; with no state yet an invalid entry is read instead
    task automatic hold();
        if (rotor == NO_STATE)
            sample_state(3'(6 + $urandom_range(0, 1)));
        else
            sample_state(rotor);
    endtask

    task automatic table_noise();
        write_entry(1'($urandom_range(0, 1)), ANGLE_W'($urandom_range(0, (1 << ANGLE_W) - 1)),
                    3'($urandom_range(0, 7)));
    endtask

    initial
    begin
        logic [DUTY_W-1:0]  duty;
        logic               dir;
        logic [COUNT_W-1:0] lim;
        int                 pick;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // table extremes, then a sample at the reset thrust of zero
        write_entry(1'b0, '0, 3'd0);
        write_entry(1'b1, '1, 3'd5);
        write_entry(1'b0, 14'h2AAA, 3'd7);
        write_entry(1'b1, 14'h1555, 3'd6);
        sample_angle('0);
        wait_drained();

        configure(8'd255, 1'b0, 4'd0);
        sample_state(3'd7);
        sample_state(3'd6);
        sample_angle('0);
        rotor = 3'd0;
        turn(1'b0);
        turn(1'b1);
        turn(1'b1);
        hold();
        turn(1'b0);
        wait_drained();

        configure(8'd1, 1'b1, 4'd15);
        sample_angle('1);
        rotor = 3'd5;
        turn(1'b0);
        turn(1'b1);
        hold();

        for (int p = 0; p < PHASES; p++)
        begin
            wait_drained();
            if (p == PHASES - 1)
                steady = 1'b1;
            duty = (p == 0) ? 8'd255 : (p == 1) ? 8'd1 : (p == 2) ? 8'd0
                 : 8'($urandom_range(1, 255));
            dir  = (p == 0) ? 1'b1 : (p == 1) ? 1'b0 : 1'($urandom_range(0, 1));
            case ($urandom_range(0, 3))
                0:       lim = 4'd0;
                1:       lim = 4'd15;
                2:       lim = 4'd1;
                default: lim = 4'($urandom_range(0, 15));
            endcase
            if (p == 0)
                lim = 4'd0;
            else if (p == 1)
                lim = 4'd15;
            configure(duty, dir, lim);
            idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 50);
            counted  = 0;
            while (counted < PHASE_ITEMS)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 48)
                    turn(1'b0);
                else if (pick < 60)
                    repeat ($urandom_range(1, 18)) turn(1'b1);
                else if (pick < 72)
                    hold();
                else
                    table_noise();
            end
        end

        // end the run with a fault: a skipped step or an invalid entry
        if (rotor == NO_STATE)
            turn(1'b0);
        if ($urandom_range(0, 1) == 0)
            sample_state(3'((int'(rotor) + $urandom_range(2, 4)) % 6));
        else
            sample_state(3'(6 + $urandom_range(0, 1)));
        repeat (6)
        begin
            if ($urandom_range(0, 1) == 0)
                sample_state(3'($urandom_range(0, 7)));
            else
                table_noise();
        end

        wait_drained();
        repeat (SETTLE) @(posedge clk);
        $display("covered %0d table writes and %0d angle samples over %0d register settings",
                 n_writes, n_samples, n_settings);
        $display("%0d results compared in order, ending in a latched fault", n_results);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
